// File: rtl/efc_pkg.sv
// Shared types, constants and helpers of the expiring FIFO cache.
package efc_pkg;

    localparam int CMD_W        = 2;
    localparam int TIME_W       = 48;
    localparam int HDL_W        = 32;
    localparam int LIFE_W       = 31;
    localparam int CNT_W        = 5;
    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RST      = 16;

    // Input word: now_time, session_handle, creation_time, lifetime (lowest bit up)
    localparam int NOW_LSB     = 0;
    localparam int HDL_LSB     = NOW_LSB + TIME_W;
    localparam int CRT_LSB     = HDL_LSB + HDL_W;
    localparam int LIFE_LSB    = CRT_LSB + TIME_W;
    localparam int S_FIELDS_W  = LIFE_LSB + LIFE_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    // Output word: accepted, found, out_handle, entry_count (lowest bit up)
    localparam int M_FIELDS_W  = 2 + HDL_W + CNT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic capture;
        logic remove;
        logic at_head;
        logic append;
        logic load_out;
        logic out_acc;
        logic out_found;
    } t_dp_ctl;

    typedef struct packed {
        logic push_ok;
        logic any_expired;
        logic count_ge_cap;
        logic count_zero;
    } t_dp_sts;

    // Creation time plus lifetime, saturated; zero on either input gives zero.
    function automatic logic [TIME_W-1:0] expiry_of(input logic [TIME_W-1:0] created,
                                                   input logic [LIFE_W-1:0] life);
        logic [TIME_W:0] sum;
        sum = {1'b0, created} + (TIME_W + 1)'(life);
        if (created == '0 || life == '0) begin
            return '0;
        end else if (sum[TIME_W]) begin
            return TIME_MAX;
        end else begin
            return sum[TIME_W-1:0];
        end
    endfunction

endpackage

// File: rtl/efc_datapath.sv
// Datapath: entry store, live count, capacity register, compares and result register.
module efc_datapath #(
    parameter int CAPACITY = efc_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [efc_pkg::CNT_W-1:0]     i_cfg_wdata,
    input  logic [efc_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  efc_pkg::t_dp_ctl              i_ctl,
    output efc_pkg::t_dp_sts              o_sts,
    output logic [efc_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import efc_pkg::*;

    // The 5-bit capacity register never allows more than 31 entries.
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int DEPTH   = (CAPACITY > CNT_MAX) ? CNT_MAX : CAPACITY;
    localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0]  r_max;
    logic [CNT_W-1:0]  r_count;
    logic [TIME_W-1:0] r_now;
    logic [HDL_W-1:0]  r_hdl;
    logic [TIME_W-1:0] r_exp;
    logic [HDL_W-1:0]  r_pop_hdl;
    logic [M_TDATA_W-1:0] r_out;
    logic [HDL_W-1:0]  r_hdl_arr [DEPTH];
    logic [TIME_W-1:0] r_exp_arr [DEPTH];

    logic [CNT_W-1:0]  cap;
    logic [DEPTH-1:0]  expd;
    logic [IW-1:0]     first_exp;
    logic [IW-1:0]     rm_idx;
    logic [HDL_W-1:0]  out_hdl;

    assign cap = (r_max > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_max;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            expd[i] = (CNT_W'(i) < r_count) && !(r_now < r_exp_arr[i]);
        end
    end

    // Lowest expired slot wins.
    always_comb begin
        first_exp = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (expd[i]) begin
                first_exp = IW'(i);
            end
        end
    end

    assign rm_idx  = i_ctl.at_head ? '0 : first_exp;
    assign out_hdl = i_ctl.out_found ? r_pop_hdl : '0;

    assign o_sts.push_ok      = (cap != '0) && (r_now < r_exp);
    assign o_sts.any_expired  = |expd;
    assign o_sts.count_ge_cap = (r_count >= cap);
    assign o_sts.count_zero   = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= CNT_W'(MAX_RST);
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (i_ctl.remove) begin
                r_count <= r_count - CNT_W'(1);
            end else if (i_ctl.append) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_now <= i_s_tdata[NOW_LSB +: TIME_W];
            r_hdl <= i_s_tdata[HDL_LSB +: HDL_W];
            r_exp <= expiry_of(i_s_tdata[CRT_LSB +: TIME_W], i_s_tdata[LIFE_LSB +: LIFE_W]);
        end
        if (i_ctl.remove && i_ctl.at_head) begin
            r_pop_hdl <= r_hdl_arr[0];
        end
        if (i_ctl.load_out) begin
            r_out <= {{M_PAD_W{1'b0}}, r_count, out_hdl, i_ctl.out_found, i_ctl.out_acc};
        end
    end

    // Close the gap at rm_idx by shifting the younger entries down one slot.
    always_ff @(posedge i_clk) begin
        if (i_ctl.remove) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (rm_idx <= IW'(i)) begin
                    r_hdl_arr[i] <= r_hdl_arr[i+1];
                    r_exp_arr[i] <= r_exp_arr[i+1];
                end
            end
        end else if (i_ctl.append) begin
            r_hdl_arr[r_count[IW-1:0]] <= r_hdl;
            r_exp_arr[r_count[IW-1:0]] <= r_exp;
        end
    end

    assign o_m_tdata = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("live count beyond store depth");

    a_remove_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.remove |-> r_count != '0)
        else $error("removal from an empty store");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.append && !i_ctl.remove |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("append did not grow the live count");
`endif

endmodule

// File: rtl/efc_ctrl.sv
// Controller: sequences prune, drop, append and pop steps for one word at a time.
module efc_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic [efc_pkg::CMD_W-1:0] i_s_tuser,
    output logic                      o_s_tready,
    input  logic                      i_m_tready,
    output logic                      o_m_tvalid,
    output efc_pkg::t_dp_ctl          o_ctl,
    input  efc_pkg::t_dp_sts          i_sts
);
    import efc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRUNE,
        S_DROP,
        S_POP,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    t_cmd    r_cmd, n_cmd;
    logic    r_acc, n_acc;
    logic    r_found, n_found;
    logic    r_out_valid, n_out_valid;
    t_dp_ctl ctl;

    always_comb begin
        ctl         = '0;
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_acc       = r_acc;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_m_tready;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    ctl.capture = 1'b1;
                    n_cmd       = t_cmd'(i_s_tuser);
                    n_acc       = 1'b0;
                    n_found     = 1'b0;
                    n_state     = (t_cmd'(i_s_tuser) == CMD_NOP) ? S_DONE : S_PRUNE;
                end
            end
            S_PRUNE: begin
                // A refused push leaves the store untouched.
                if (r_cmd == CMD_PUSH && !i_sts.push_ok) begin
                    n_state = S_DONE;
                end else if (i_sts.any_expired) begin
                    ctl.remove = 1'b1;
                end else begin
                    case (r_cmd)
                        CMD_PUSH: n_state = S_DROP;
                        CMD_POP:  n_state = S_POP;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_DROP: begin
                if (i_sts.count_ge_cap) begin
                    ctl.remove  = 1'b1;
                    ctl.at_head = 1'b1;
                end else begin
                    ctl.append = 1'b1;
                    n_acc      = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_POP: begin
                if (!i_sts.count_zero) begin
                    ctl.remove  = 1'b1;
                    ctl.at_head = 1'b1;
                    n_found     = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hold until the result register is free.
                if (!r_out_valid || i_m_tready) begin
                    ctl.load_out  = 1'b1;
                    ctl.out_acc   = r_acc;
                    ctl.out_found = r_found;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd       <= CMD_NOP;
            r_acc       <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_acc       <= n_acc;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_ctl      = ctl;

`ifndef SYNTHESIS
    a_drop_after_prune: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DROP |-> !i_sts.any_expired)
        else $error("capacity drop reached with expired entries left");
`endif

endmodule

// File: rtl/expiring_fifo_cache_top.sv
// Steps: S_IDLE captures; command 3 goes to S_DONE, others prune expired entries in S_PRUNE
//   (not for a refused push); a push drops oldest to fit and appends, a pop takes the head.
// Throughput: one word at a time; the next word is taken at the edge where the previous
//   result can first be taken; S_DONE waits while the previous result is still held.
// Reset (synchronous, active low): live count 0, capacity register 16, no result
//   pending. Entry store is not cleared; only slots below the live count are read.
module expiring_fifo_cache_top #(
    parameter int CAPACITY = efc_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [efc_pkg::CNT_W-1:0]     i_cfg_wdata,   // max_entries
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // now_time[47:0], session_handle[79:48], creation_time[127:80], lifetime[158:128]
    input  logic [efc_pkg::S_TDATA_W-1:0] i_s_tdata,
    // cmd[1:0]
    input  logic [efc_pkg::CMD_W-1:0]     i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // accepted[0], found[1], out_handle[33:2], entry_count[38:34]
    output logic [efc_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import efc_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;

    efc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_ctl      (ctl),
        .i_sts      (sts)
    );

    efc_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
